// ===== hdl/tsd_pkg.sv =====
// Shared types and codes for the TGA image stream decoder.
// No dependencies; every other file takes names from here by scope.
package tsd_pkg;

  localparam logic [1:0] KIND_PIXEL  = 2'd0;
  localparam logic [1:0] KIND_HEADER = 2'd1;
  localparam logic [1:0] KIND_ERROR  = 2'd2;

  localparam logic [7:0] RLE_IMAGE_TYPE = 8'd10;
  localparam logic [7:0] DEPTH_16 = 8'd16;
  localparam logic [7:0] DEPTH_24 = 8'd24;
  localparam logic [7:0] DEPTH_32 = 8'd32;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       file_start;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic [7:0]  repeat_res;
    logic        last_of_image;
    logic [15:0] image_width;
    logic [15:0] image_height;
    logic [2:0]  channels;
  } result_t;

endpackage

// ===== hdl/tga_image_stream_decoder.sv =====
// TGA image stream decoder, top level: input register, parser, result register.
// A byte waits in the input register for its parse step; its result, if any, goes to the result register.
// Throughput: one byte per cycle, set by the single parse step per byte; a held
// result stalls the byte waiting in the input register.
// Reset (synchronous, rst high) puts the parser at header byte 0, both registers empty.
// Depends on tsd_pkg, tsd_in_reg, tsd_parser and tsd_out_reg.
module tga_image_stream_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        file_start,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  kind,
  output logic [7:0]  red,
  output logic [7:0]  green,
  output logic [7:0]  blue,
  output logic [7:0]  alpha,
  output logic [7:0]  repeat_res,
  output logic        last_of_image,
  output logic [15:0] image_width,
  output logic [15:0] image_height,
  output logic [2:0]  channels
);

  tsd_pkg::in_item_t in_item, item;
  tsd_pkg::result_t  res_comb, res;
  logic in_full, out_full, step, res_valid;

  assign in_item.data_byte  = data_byte;
  assign in_item.file_start = file_start;

  assign step = in_full && (!out_full || out_ready);

  tsd_in_reg u_in_reg (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .take     (step),
    .full     (in_full),
    .item     (item)
  );

  tsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (item),
    .res_valid (res_valid),
    .res       (res_comb)
  );

  tsd_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .load      (step && res_valid),
    .res_in    (res_comb),
    .full      (out_full),
    .out_ready (out_ready),
    .res       (res)
  );

  assign out_valid     = out_full;
  assign kind          = res.kind;
  assign red           = res.red;
  assign green         = res.green;
  assign blue          = res.blue;
  assign alpha         = res.alpha;
  assign repeat_res    = res.repeat_res;
  assign last_of_image = res.last_of_image;
  assign image_width   = res.image_width;
  assign image_height  = res.image_height;
  assign channels      = res.channels;

endmodule

// ===== hdl/tsd_in_reg.sv =====
// Input register of the TGA decoder: holds one accepted byte for the parser.
// Depends on tsd_pkg.
module tsd_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  tsd_pkg::in_item_t in_item,
  input  logic              take,
  output logic              full,
  output tsd_pkg::in_item_t item
);

  assign in_ready = !full || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (in_ready) begin
      full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

// ===== hdl/tsd_parser.sv =====
// Header, skip and pixel parser of the TGA decoder: holds all parse state and
// builds at most one result per byte. Depends on tsd_pkg.
module tsd_parser (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  tsd_pkg::in_item_t item,
  output logic              res_valid,
  output tsd_pkg::result_t  res
);

  localparam logic [2:0] PH_HEADER = 3'd0;
  localparam logic [2:0] PH_SKIP   = 3'd1;
  localparam logic [2:0] PH_PLAIN  = 3'd2;
  localparam logic [2:0] PH_PACKET = 3'd3;
  localparam logic [2:0] PH_RUNPIX = 3'd4;
  localparam logic [2:0] PH_DONE   = 3'd5;

  logic [2:0]  phase, phase_next;
  logic [4:0]  header_position, header_position_next;
  logic [7:0]  id_length, id_length_next;
  logic [7:0]  image_kind, image_kind_next;
  logic [15:0] width_store, width_store_next;
  logic [15:0] height_store, height_store_next;
  logic [7:0]  bit_depth, bit_depth_next;
  logic [8:0]  skip_remaining, skip_remaining_next;
  logic [31:0] pixels_remaining, pixels_remaining_next;
  logic        packet_is_repeat, packet_is_repeat_next;
  logic [7:0]  packet_count, packet_count_next;
  logic [1:0]  byte_in_pixel, byte_in_pixel_next;
  logic [31:0] color_bytes, color_bytes_next;

  logic [2:0]  e_phase;
  logic [4:0]  e_hpos;
  logic [7:0]  e_id_length, e_image_kind, e_bit_depth, e_packet_count;
  logic [15:0] e_width, e_height;
  logic [8:0]  e_skip;
  logic [31:0] e_pixrem, e_color;
  logic        e_repeat;
  logic [1:0]  e_bip;

  logic [7:0]  d;
  logic        clr;
  logic        is_rle, depth_ok, pix_done;
  logic [2:0]  nbytes;
  logic [31:0] color_acc, want, rep, pixrem_left, area;
  logic [8:0]  skip_dec;
  logic [7:0]  r_col, g_col, b_col, a_col;

  assign d   = item.data_byte;
  assign clr = item.file_start;

  // Clear the parser before this byte when it opens a new file.
  assign e_phase        = clr ? PH_HEADER : phase;
  assign e_hpos         = clr ? '0 : header_position;
  assign e_id_length    = clr ? '0 : id_length;
  assign e_image_kind   = clr ? '0 : image_kind;
  assign e_width        = clr ? '0 : width_store;
  assign e_height       = clr ? '0 : height_store;
  assign e_bit_depth    = clr ? '0 : bit_depth;
  assign e_skip         = clr ? '0 : skip_remaining;
  assign e_pixrem       = clr ? '0 : pixels_remaining;
  assign e_repeat       = clr ? 1'b0 : packet_is_repeat;
  assign e_packet_count = clr ? '0 : packet_count;
  assign e_bip          = clr ? '0 : byte_in_pixel;
  assign e_color        = clr ? '0 : color_bytes;

  assign is_rle   = (e_image_kind == tsd_pkg::RLE_IMAGE_TYPE);
  assign depth_ok = (d == tsd_pkg::DEPTH_24) || (d == tsd_pkg::DEPTH_32) ||
                    ((d == tsd_pkg::DEPTH_16) && !is_rle);
  assign area     = {16'd0, e_width} * {16'd0, e_height};
  assign skip_dec = e_skip - 9'd1;

  always_comb begin
    if (e_bit_depth == tsd_pkg::DEPTH_16) begin
      nbytes = 3'd2;
    end else if (e_bit_depth == tsd_pkg::DEPTH_32) begin
      nbytes = 3'd4;
    end else begin
      nbytes = 3'd3;
    end
  end

  assign color_acc = e_color | ({24'd0, d} << {e_bip, 3'b000});
  assign pix_done  = (({1'b0, e_bip} + 3'd1) >= nbytes);

  assign want = (e_phase == PH_RUNPIX && e_repeat) ? {24'd0, e_packet_count} : 32'd1;
  assign rep  = (want < e_pixrem) ? want : e_pixrem;
  assign pixrem_left = e_pixrem - rep;

  always_comb begin
    a_col = '0;
    if (e_bit_depth == tsd_pkg::DEPTH_16) begin
      b_col = {color_acc[4:0], 3'b000};
      g_col = {color_acc[9:5], 3'b000};
      r_col = {color_acc[14:10], 3'b000};
    end else begin
      b_col = color_acc[7:0];
      g_col = color_acc[15:8];
      r_col = color_acc[23:16];
      if (e_bit_depth == tsd_pkg::DEPTH_32) begin
        a_col = color_acc[31:24];
      end
    end
  end

  always_comb begin
    phase_next            = e_phase;
    header_position_next  = e_hpos;
    id_length_next        = e_id_length;
    image_kind_next       = e_image_kind;
    width_store_next      = e_width;
    height_store_next     = e_height;
    bit_depth_next        = e_bit_depth;
    skip_remaining_next   = e_skip;
    pixels_remaining_next = e_pixrem;
    packet_is_repeat_next = e_repeat;
    packet_count_next     = e_packet_count;
    byte_in_pixel_next    = e_bip;
    color_bytes_next      = e_color;
    res_valid             = 1'b0;
    res                   = '0;

    unique case (e_phase)
      PH_HEADER: begin
        if (e_hpos < 5'd16) begin
          header_position_next = e_hpos + 5'd1;
        end
        unique case (e_hpos)
          5'd0:  id_length_next = d;
          5'd2:  image_kind_next = d;
          5'd12: width_store_next = {e_width[15:8], d};
          5'd13: width_store_next = {d, e_width[7:0]};
          5'd14: height_store_next = {e_height[15:8], d};
          5'd15: height_store_next = {d, e_height[7:0]};
          5'd16: begin
            bit_depth_next = d;
            res_valid = 1'b1;
            if (!depth_ok) begin
              res.kind = tsd_pkg::KIND_ERROR;
              phase_next = PH_DONE;
            end else begin
              pixels_remaining_next = area;
              res.kind = tsd_pkg::KIND_HEADER;
              res.image_width = e_width;
              res.image_height = e_height;
              res.channels = (d == tsd_pkg::DEPTH_32) ? 3'd4 : 3'd3;
              if (e_width == 16'd0 || e_height == 16'd0) begin
                res.last_of_image = 1'b1;
                phase_next = PH_DONE;
              end else begin
                skip_remaining_next = {1'b0, e_id_length} + 9'd1;
                phase_next = PH_SKIP;
              end
            end
          end
          default: ;
        endcase
      end
      PH_SKIP: begin
        skip_remaining_next = skip_dec;
        if (skip_dec == 9'd0) begin
          byte_in_pixel_next = '0;
          color_bytes_next = '0;
          phase_next = is_rle ? PH_PACKET : PH_PLAIN;
        end
      end
      PH_PACKET: begin
        if (d < 8'd128) begin
          packet_is_repeat_next = 1'b0;
          packet_count_next = d + 8'd1;
        end else begin
          packet_is_repeat_next = 1'b1;
          packet_count_next = d - 8'd127;
        end
        byte_in_pixel_next = '0;
        color_bytes_next = '0;
        phase_next = PH_RUNPIX;
      end
      PH_PLAIN, PH_RUNPIX: begin
        if (!pix_done) begin
          color_bytes_next = color_acc;
          byte_in_pixel_next = e_bip + 2'd1;
        end else begin
          byte_in_pixel_next = '0;
          color_bytes_next = '0;
          pixels_remaining_next = pixrem_left;
          res_valid = 1'b1;
          res.kind = tsd_pkg::KIND_PIXEL;
          res.red = r_col;
          res.green = g_col;
          res.blue = b_col;
          res.alpha = a_col;
          res.repeat_res = rep[7:0];
          res.last_of_image = (pixrem_left == 32'd0);
          if (e_phase == PH_RUNPIX) begin
            packet_count_next = e_repeat ? 8'd0 : e_packet_count - 8'd1;
          end
          if (pixrem_left == 32'd0) begin
            phase_next = PH_DONE;
          end else if (e_phase == PH_RUNPIX &&
                       (e_repeat || e_packet_count == 8'd1)) begin
            phase_next = PH_PACKET;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_HEADER;
      header_position  <= '0;
      id_length        <= '0;
      image_kind       <= '0;
      width_store      <= '0;
      height_store     <= '0;
      bit_depth        <= '0;
      skip_remaining   <= '0;
      pixels_remaining <= '0;
      packet_is_repeat <= 1'b0;
      packet_count     <= '0;
      byte_in_pixel    <= '0;
      color_bytes      <= '0;
    end else if (step) begin
      phase            <= phase_next;
      header_position  <= header_position_next;
      id_length        <= id_length_next;
      image_kind       <= image_kind_next;
      width_store      <= width_store_next;
      height_store     <= height_store_next;
      bit_depth        <= bit_depth_next;
      skip_remaining   <= skip_remaining_next;
      pixels_remaining <= pixels_remaining_next;
      packet_is_repeat <= packet_is_repeat_next;
      packet_count     <= packet_count_next;
      byte_in_pixel    <= byte_in_pixel_next;
      color_bytes      <= color_bytes_next;
    end
  end

endmodule

// ===== hdl/tsd_out_reg.sv =====
// Result register of the TGA decoder: holds one result until its transfer.
// Depends on tsd_pkg.
module tsd_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  tsd_pkg::result_t res_in,
  output logic             full,
  input  logic             out_ready,
  output tsd_pkg::result_t res
);

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (load) begin
      full <= 1'b1;
    end else if (out_ready) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= res_in;
    end
  end

endmodule

// ===== bench/tga_image_stream_decoder_test.sv =====
// Self-checking bench for tga_image_stream_decoder: directed and random TGA byte streams,
// with a cycle-free decoder model in the bench predicting every header, run and error result.
// Depends on tsd_pkg and the decoder RTL only.
module tga_image_stream_decoder_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 1550;
  localparam int IDLE_LIMIT   = 2000;
  localparam int DRAIN_CYCLES = 8;

  localparam int OFS_ID_LENGTH  = 0;
  localparam int OFS_IMAGE_TYPE = 2;
  localparam int OFS_WIDTH_LO   = 12;
  localparam int OFS_WIDTH_HI   = 13;
  localparam int OFS_HEIGHT_LO  = 14;
  localparam int OFS_HEIGHT_HI  = 15;
  localparam int OFS_DEPTH      = 16;
  localparam int HEADER_BYTES   = 18;

  localparam logic [7:0] PLAIN_IMAGE_TYPE = 8'd2;
  localparam logic [7:0] REPEAT_PACKET    = 8'd128;
  localparam logic [7:0] REPEAT_BIAS      = 8'd127;

  typedef enum logic [2:0] {
    P_HEADER, P_SKIP, P_PLAIN, P_PACKET, P_RUNPIX, P_DONE
  } decode_phase_e;

  typedef enum int {READY_ALWAYS, READY_MOSTLY, READY_PATTERN, READY_SPARSE} ready_mode_e;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = 8'd0;
  logic        file_start = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  kind;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [7:0]  repeat_res;
  logic        last_of_image;
  logic [15:0] image_width;
  logic [15:0] image_height;
  logic [2:0]  channels;

  tga_image_stream_decoder u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .file_start(file_start),
    .out_valid(out_valid), .out_ready(out_ready),
    .kind(kind), .red(red), .green(green), .blue(blue), .alpha(alpha),
    .repeat_res(repeat_res), .last_of_image(last_of_image),
    .image_width(image_width), .image_height(image_height), .channels(channels)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  decode_phase_e phase = P_HEADER;
  logic [4:0]  hdr_pos;
  logic [7:0]  id_len;
  logic [7:0]  img_type;
  logic [15:0] img_w;
  logic [15:0] img_h;
  logic [7:0]  depth;
  logic [8:0]  skip_left;
  logic [31:0] pix_left;
  logic        run_is_rep;
  logic [7:0]  run_count;
  logic [1:0]  byte_pos;
  logic [31:0] color_acc;

  tsd_pkg::result_t expected_decodes[$];
  logic [7:0]  file_q[$];
  int          live_bytes = 0;
  int          errors = 0;
  int          burst_left = 0;
  int          idle_cycles = 0;

  function automatic void clear_decoder();
    phase = P_HEADER;
    hdr_pos = '0;
    id_len = '0;
    img_type = '0;
    img_w = '0;
    img_h = '0;
    depth = '0;
    skip_left = '0;
    pix_left = '0;
    run_is_rep = 1'b0;
    run_count = '0;
    byte_pos = '0;
    color_acc = '0;
  endfunction

  function automatic int pixel_width(input logic [7:0] dep);
    return (dep == tsd_pkg::DEPTH_16) ? 2 : ((dep == tsd_pkg::DEPTH_32) ? 4 : 3);
  endfunction

  function automatic bit gather_byte(input logic [7:0] d);
    int pos;
    pos = byte_pos;
    color_acc |= 32'(d) << (8 * pos);
    if (pos + 1 >= pixel_width(depth)) begin
      byte_pos = '0;
      return 1'b1;
    end
    byte_pos = 2'(pos + 1);
    return 1'b0;
  endfunction

  function automatic tsd_pkg::result_t emit_run(input logic [7:0] want);
    tsd_pkg::result_t r;
    logic [31:0]      n;
    r = '0;
    if (depth == tsd_pkg::DEPTH_16) begin
      r.blue  = {color_acc[4:0], 3'b000};
      r.green = {color_acc[9:5], 3'b000};
      r.red   = {color_acc[14:10], 3'b000};
    end else begin
      r.blue  = color_acc[7:0];
      r.green = color_acc[15:8];
      r.red   = color_acc[23:16];
      if (depth == tsd_pkg::DEPTH_32) r.alpha = color_acc[31:24];
    end
    color_acc = '0;
    n = (32'(want) < pix_left) ? 32'(want) : pix_left;
    pix_left -= n;
    r.kind = tsd_pkg::KIND_PIXEL;
    r.repeat_res = n[7:0];
    r.last_of_image = (pix_left == 0);
    if (pix_left == 0) phase = P_DONE;
    return r;
  endfunction

  function automatic bit decode_byte(input logic [7:0] d, input logic fs,
                                     output tsd_pkg::result_t r);
    int pos;
    r = '0;
    if (fs) clear_decoder();
    if (phase != P_DONE) live_bytes++;
    case (phase)
      P_HEADER: begin
        pos = hdr_pos;
        if (pos < OFS_DEPTH) hdr_pos = 5'(pos + 1);
        case (pos)
          OFS_ID_LENGTH:  id_len = d;
          OFS_IMAGE_TYPE: img_type = d;
          OFS_WIDTH_LO:   img_w[7:0] = d;
          OFS_WIDTH_HI:   img_w[15:8] = d;
          OFS_HEIGHT_LO:  img_h[7:0] = d;
          OFS_HEIGHT_HI:  img_h[15:8] = d;
          OFS_DEPTH: begin
            depth = d;
            if (!(d == tsd_pkg::DEPTH_24 || d == tsd_pkg::DEPTH_32 ||
                  (d == tsd_pkg::DEPTH_16 &&
                   img_type != tsd_pkg::RLE_IMAGE_TYPE))) begin
              r.kind = tsd_pkg::KIND_ERROR;
              phase = P_DONE;
            end else begin
              pix_left = 32'(img_w) * 32'(img_h);
              r.kind = tsd_pkg::KIND_HEADER;
              r.image_width = img_w;
              r.image_height = img_h;
              r.channels = (d == tsd_pkg::DEPTH_32) ? 3'd4 : 3'd3;
              if (pix_left == 0) begin
                r.last_of_image = 1'b1;
                phase = P_DONE;
              end else begin
                skip_left = 9'(id_len) + 9'd1;
                phase = P_SKIP;
              end
            end
            return 1'b1;
          end
          default: ;
        endcase
        return 1'b0;
      end
      P_SKIP: begin
        skip_left = skip_left - 9'd1;
        if (skip_left == 0) begin
          byte_pos = '0;
          color_acc = '0;
          phase = (img_type == tsd_pkg::RLE_IMAGE_TYPE) ? P_PACKET : P_PLAIN;
        end
        return 1'b0;
      end
      P_PLAIN: begin
        if (!gather_byte(d)) return 1'b0;
        r = emit_run(8'd1);
        return 1'b1;
      end
      P_PACKET: begin
        if (d < REPEAT_PACKET) begin
          run_is_rep = 1'b0;
          run_count = d + 8'd1;
        end else begin
          run_is_rep = 1'b1;
          run_count = d - REPEAT_BIAS;
        end
        byte_pos = '0;
        color_acc = '0;
        phase = P_RUNPIX;
        return 1'b0;
      end
      P_RUNPIX: begin
        if (!gather_byte(d)) return 1'b0;
        if (run_is_rep) begin
          r = emit_run(run_count);
          run_count = '0;
        end else begin
          r = emit_run(8'd1);
          run_count = run_count - 8'd1;
        end
        if (phase != P_DONE && run_count == 0) phase = P_PACKET;
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch at %0t ns: %s got %0h expected %0h", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    tsd_pkg::result_t pred;
    tsd_pkg::result_t seen;
    tsd_pkg::result_t want;
    if (!rst) begin
      if (in_valid && in_ready) begin
        if (decode_byte(data_byte, file_start, pred)) expected_decodes.push_back(pred);
      end
      if (out_valid && out_ready) begin
        seen.kind = kind;
        seen.red = red;
        seen.green = green;
        seen.blue = blue;
        seen.alpha = alpha;
        seen.repeat_res = repeat_res;
        seen.last_of_image = last_of_image;
        seen.image_width = image_width;
        seen.image_height = image_height;
        seen.channels = channels;
        if (expected_decodes.size() == 0) begin
          report_mismatch("result with nothing pending, kind", 32'(kind), '0);
        end else begin
          want = expected_decodes.pop_front();
          if (seen.kind !== want.kind)
            report_mismatch("kind", 32'(seen.kind), 32'(want.kind));
          if (seen.red !== want.red)
            report_mismatch("red", 32'(seen.red), 32'(want.red));
          if (seen.green !== want.green)
            report_mismatch("green", 32'(seen.green), 32'(want.green));
          if (seen.blue !== want.blue)
            report_mismatch("blue", 32'(seen.blue), 32'(want.blue));
          if (seen.alpha !== want.alpha)
            report_mismatch("alpha", 32'(seen.alpha), 32'(want.alpha));
          if (seen.repeat_res !== want.repeat_res)
            report_mismatch("repeat_res", 32'(seen.repeat_res), 32'(want.repeat_res));
          if (seen.last_of_image !== want.last_of_image)
            report_mismatch("last_of_image", 32'(seen.last_of_image),
                            32'(want.last_of_image));
          if (seen.image_width !== want.image_width)
            report_mismatch("image_width", 32'(seen.image_width), 32'(want.image_width));
          if (seen.image_height !== want.image_height)
            report_mismatch("image_height", 32'(seen.image_height),
                            32'(want.image_height));
          if (seen.channels !== want.channels)
            report_mismatch("channels", 32'(seen.channels), 32'(want.channels));
        end
      end
    end
  end

  ready_mode_e ready_mode = READY_ALWAYS;
  int          ready_span = 0;
  int          ready_tick = 0;
  logic [7:0]  ready_pattern = 8'hB5;

  always @(posedge clk) begin
    if (ready_span == 0) begin
      ready_mode = ready_mode_e'($urandom_range(0, 3));
      ready_span = $urandom_range(16, 160);
      ready_pattern = 8'($urandom) | 8'h01;
    end
    ready_span--;
    ready_tick++;
    case (ready_mode)
      READY_ALWAYS:  out_ready <= 1'b1;
      READY_MOSTLY:  out_ready <= ($urandom_range(0, 9) < 7);
      READY_PATTERN: out_ready <= ready_pattern[3'(ready_tick)];
      default:       out_ready <= ($urandom_range(0, 3) == 0);
    endcase
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("** tga_image_stream_decoder: FAILED **");
        $finish;
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic fs);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    in_valid <= 1'b1;
    data_byte <= d;
    file_start <= fs;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_file(input bit with_start);
    foreach (file_q[i]) send_byte(file_q[i], with_start && (i == 0));
    file_q.delete();
  endtask

  function automatic logic [7:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic add_header(input logic [7:0] id, input logic [7:0] typ,
                            input logic [15:0] w, input logic [15:0] h,
                            input logic [7:0] dep);
    logic [7:0] b;
    for (int i = 0; i < HEADER_BYTES; i++) begin
      b = rand_sample();
      case (i)
        OFS_ID_LENGTH:  b = id;
        OFS_IMAGE_TYPE: b = typ;
        OFS_WIDTH_LO:   b = w[7:0];
        OFS_WIDTH_HI:   b = w[15:8];
        OFS_HEIGHT_LO:  b = h[7:0];
        OFS_HEIGHT_HI:  b = h[15:8];
        OFS_DEPTH:      b = dep;
        default: ;
      endcase
      file_q.push_back(b);
    end
    repeat (int'(id)) file_q.push_back(rand_sample());
  endtask

  task automatic add_pixels(input int n, input logic [7:0] dep);
    repeat (n * pixel_width(dep)) file_q.push_back(rand_sample());
  endtask

  task automatic test_plain_formats();
    add_header(8'd0, PLAIN_IMAGE_TYPE, 16'd2, 16'd1, tsd_pkg::DEPTH_24);
    file_q.push_back(8'h00); file_q.push_back(8'h00); file_q.push_back(8'h00);
    file_q.push_back(8'hFF); file_q.push_back(8'hFF); file_q.push_back(8'hFF);
    file_q.push_back(8'hAA);
    send_file(1'b0);
    add_header(8'd1, PLAIN_IMAGE_TYPE, 16'd1, 16'd1, tsd_pkg::DEPTH_32);
    file_q.push_back(8'h00); file_q.push_back(8'hFF);
    file_q.push_back(8'h5A); file_q.push_back(8'hA5);
    send_file(1'b1);
    add_header(8'd0, PLAIN_IMAGE_TYPE, 16'd3, 16'd1, tsd_pkg::DEPTH_16);
    file_q.push_back(8'hFF); file_q.push_back(8'hFF);
    file_q.push_back(8'h00); file_q.push_back(8'h00);
    file_q.push_back(8'hAA); file_q.push_back(8'h55);
    send_file(1'b1);
  endtask

  task automatic test_rle_runs();
    add_header(8'd0, tsd_pkg::RLE_IMAGE_TYPE, 16'd2, 16'd2, tsd_pkg::DEPTH_24);
    file_q.push_back(8'h81); add_pixels(1, tsd_pkg::DEPTH_24);
    file_q.push_back(8'h00); add_pixels(1, tsd_pkg::DEPTH_24);
    file_q.push_back(8'hFF); add_pixels(1, tsd_pkg::DEPTH_24);
    send_file(1'b1);
    add_header(8'd2, tsd_pkg::RLE_IMAGE_TYPE, 16'd3, 16'd1, tsd_pkg::DEPTH_32);
    file_q.push_back(8'h02); add_pixels(3, tsd_pkg::DEPTH_32);
    send_file(1'b1);
    add_header(8'd0, tsd_pkg::RLE_IMAGE_TYPE, 16'd1, 16'd1, tsd_pkg::DEPTH_24);
    file_q.push_back(8'h7F); add_pixels(3, tsd_pkg::DEPTH_24);
    send_file(1'b1);
  endtask

  task automatic test_unsupported_depths();
    add_header(8'd0, tsd_pkg::RLE_IMAGE_TYPE, 16'd1, 16'd1, tsd_pkg::DEPTH_16);
    add_pixels(2, tsd_pkg::DEPTH_16);
    send_file(1'b1);
    add_header(8'd0, PLAIN_IMAGE_TYPE, 16'd1, 16'd1, 8'd8);
    send_file(1'b1);
    add_header(8'd0, PLAIN_IMAGE_TYPE, 16'd1, 16'd1, 8'd0);
    send_file(1'b1);
    add_header(8'd0, tsd_pkg::RLE_IMAGE_TYPE, 16'd1, 16'd1, 8'hFF);
    send_file(1'b1);
  endtask

  task automatic test_header_extremes();
    add_header(8'd0, PLAIN_IMAGE_TYPE, 16'hFFFF, 16'd0, tsd_pkg::DEPTH_24);
    add_pixels(1, tsd_pkg::DEPTH_24);
    send_file(1'b1);
    add_header(8'd0, tsd_pkg::RLE_IMAGE_TYPE, 16'd0, 16'hFFFF, tsd_pkg::DEPTH_32);
    send_file(1'b1);
    add_header(8'd0, PLAIN_IMAGE_TYPE, 16'hFFFF, 16'hFFFF, tsd_pkg::DEPTH_32);
    add_pixels(1, tsd_pkg::DEPTH_32);
    send_file(1'b1);
    add_header(8'd255, PLAIN_IMAGE_TYPE, 16'd1, 16'd1, tsd_pkg::DEPTH_24);
    add_pixels(1, tsd_pkg::DEPTH_24);
    send_file(1'b1);
  endtask

  task automatic add_random_file();
    logic [7:0]  id;
    logic [7:0]  typ;
    logic [7:0]  dep;
    logic [15:0] w;
    logic [15:0] h;
    int          pixels;
    int          cnt;
    int          roll;
    roll = $urandom_range(0, 99);
    id = (roll < 80) ? 8'($urandom_range(0, 3)) :
         (roll < 98) ? 8'($urandom_range(4, 40)) : 8'($urandom_range(200, 255));
    roll = $urandom_range(0, 99);
    typ = (roll < 55) ? tsd_pkg::RLE_IMAGE_TYPE :
          (roll < 90) ? PLAIN_IMAGE_TYPE : 8'($urandom);
    roll = $urandom_range(0, 99);
    if (roll < 92) begin
      case ($urandom_range(0, 4))
        0, 1:    dep = tsd_pkg::DEPTH_24;
        2, 3:    dep = tsd_pkg::DEPTH_32;
        default: dep = tsd_pkg::DEPTH_16;
      endcase
    end else begin
      dep = 8'($urandom);
    end
    w = 16'($urandom_range(1, 5));
    h = 16'($urandom_range(1, 4));
    if ($urandom_range(0, 19) == 0) begin
      if ($urandom_range(0, 1) == 1) w = '0;
      else h = '0;
    end
    add_header(id, typ, w, h, dep);
    pixels = int'(w) * int'(h);
    if (typ == tsd_pkg::RLE_IMAGE_TYPE) begin
      while (pixels > 0) begin
        if ($urandom_range(0, 1) == 1) begin
          cnt = ($urandom_range(0, 9) < 8) ? $urandom_range(1, (pixels < 128) ? pixels : 128)
                                           : $urandom_range(1, 128);
          file_q.push_back(8'(int'(REPEAT_BIAS) + cnt));
          add_pixels(1, dep);
        end else begin
          cnt = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 8) : $urandom_range(1, 128);
          file_q.push_back(8'(cnt - 1));
          add_pixels((cnt < pixels) ? cnt : pixels, dep);
        end
        pixels -= cnt;
      end
    end else begin
      add_pixels(pixels, dep);
    end
    if ($urandom_range(0, 9) == 0) begin
      cnt = $urandom_range(1, file_q.size());
      while (file_q.size() > cnt) void'(file_q.pop_back());
    end
    if ($urandom_range(0, 19) == 0) repeat ($urandom_range(1, 4)) file_q.push_back(rand_sample());
    send_file($urandom_range(0, 19) != 0);
  endtask

  task automatic test_random_files();
    while (live_bytes < RANDOM_ITEMS) begin
      if ($urandom_range(0, 19) == 0) begin
        repeat ($urandom_range(3, 10)) send_byte(8'($urandom), $urandom_range(0, 4) == 0);
      end else begin
        add_random_file();
      end
    end
  endtask

  initial begin
    clear_decoder();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_plain_formats();
    test_rle_runs();
    test_unsupported_depths();
    test_header_extremes();
    test_random_files();
    in_valid <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** tga_image_stream_decoder: PASSED **");
    end else begin
      $display("** tga_image_stream_decoder: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/tsd_pkg.sv
hdl/tsd_in_reg.sv
hdl/tsd_parser.sv
hdl/tsd_out_reg.sv
hdl/tga_image_stream_decoder.sv
bench/tga_image_stream_decoder_test.sv
